@@ design/cptq_pkg.sv @@
// shared types, constants and helpers for the can priority transmit queue
package cptq_pkg;

	localparam int NUM_PRIORITIES_DEF = 4;
	localparam int QUEUE_LIMIT_DEF    = 15;
	localparam int MAX_DATA_BYTES     = 8;

	localparam int CMD_W  = 1;
	localparam int PRIO_W = 2;
	localparam int ID_W   = 11;
	localparam int LEN_W  = 4;
	localparam int DATA_W = 64;
	localparam int HDR_W  = ID_W + LEN_W;
	localparam int SLOT_W = HDR_W + DATA_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQUEUE = 1'b0,
		CMD_SEND    = 1'b1
	} cmd_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic flushed;
		logic len_err;
	} ctl_t;

	function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_DATA_BYTES; i++) begin
			m[i*8 +: 8] = (len > LEN_W'(i)) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

@@ design/can_priority_tx_queue.sv @@
// top level of the strict priority can transmit queue
// usage:
//   a command word is taken on the clock edge where start is high and busy
//   is low; busy stays low, so one word can be taken every cycle
//   command enqueue stores id, length and data in the fifo named by
//   priority_req (0 is highest); length above 8 gives length_error, and a
//   fifo holding more than QUEUE_LIMIT frames is emptied first (queue_flushed)
//   command send pops the front frame of the highest non-empty fifo onto
//   frame_valid, frame_id, frame_length and frame_data, or an all-zero word
//   every command gives exactly one result word, marked by done for one cycle
//   each word passes the input register, the slot ram read register and
//   the result register before its result appears with done
//   throughput is one word per cycle; the queue registers update in the
//   cycle after acceptance so the next word sees them directly
//   asynchronous reset empties every fifo and drops words in flight
//   results cannot be held off, the receiver must take done when it comes
module can_priority_tx_queue #(
	parameter int NUM_PRIORITIES = cptq_pkg::NUM_PRIORITIES_DEF,
	parameter int QUEUE_LIMIT    = cptq_pkg::QUEUE_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [cptq_pkg::CMD_W-1:0]  command,
	input  logic [cptq_pkg::PRIO_W-1:0] priority_req,
	input  logic [cptq_pkg::ID_W-1:0]   msg_id,
	input  logic [cptq_pkg::LEN_W-1:0]  msg_length,
	input  logic [cptq_pkg::DATA_W-1:0] msg_data,
	output logic                        done,
	output logic                        frame_valid,
	output logic [cptq_pkg::ID_W-1:0]   frame_id,
	output logic [cptq_pkg::LEN_W-1:0]  frame_length,
	output logic [cptq_pkg::DATA_W-1:0] frame_data,
	output logic                        length_error,
	output logic                        queue_flushed
);

	localparam int SLOTS  = QUEUE_LIMIT + 1;
	localparam int DEPTH  = NUM_PRIORITIES * SLOTS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic                        valid_s1;
	cptq_pkg::cmd_t              cmd_s1;
	logic [cptq_pkg::PRIO_W-1:0] prio_s1;
	logic [cptq_pkg::ID_W-1:0]   id_s1;
	logic [cptq_pkg::LEN_W-1:0]  len_s1;
	logic [cptq_pkg::DATA_W-1:0] data_s1;

	cptq_pkg::ctl_t              ctl;
	logic [ADDR_W-1:0]           addr;
	logic [cptq_pkg::SLOT_W-1:0] wdata;
	logic [cptq_pkg::SLOT_W-1:0] rdata;

	logic valid_s2;
	logic hit_s2;
	logic len_err_s2;
	logic flushed_s2;

	logic                        done_q;
	logic                        frame_valid_s3;
	logic [cptq_pkg::ID_W-1:0]   frame_id_s3;
	logic [cptq_pkg::LEN_W-1:0]  frame_length_s3;
	logic [cptq_pkg::DATA_W-1:0] frame_data_s3;
	logic                        length_error_s3;
	logic                        queue_flushed_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1     <= cptq_pkg::cmd_t'(command);
		prio_s1    <= priority_req;
		id_s1      <= msg_id;
		len_s1     <= msg_length;
		data_s1    <= msg_data;
		hit_s2     <= ctl.rd;
		len_err_s2 <= ctl.len_err;
		flushed_s2 <= ctl.flushed;
		frame_valid_s3   <= hit_s2;
		frame_id_s3      <= hit_s2 ? rdata[cptq_pkg::DATA_W +: cptq_pkg::ID_W] : '0;
		frame_length_s3  <= hit_s2 ? rdata[cptq_pkg::DATA_W + cptq_pkg::ID_W +: cptq_pkg::LEN_W]
			: '0;
		frame_data_s3    <= hit_s2 ? rdata[cptq_pkg::DATA_W-1:0] : '0;
		length_error_s3  <= len_err_s2;
		queue_flushed_s3 <= flushed_s2;
	end

	cptq_qstate #(
		.NUM_PRIORITIES(NUM_PRIORITIES),
		.QUEUE_LIMIT   (QUEUE_LIMIT),
		.ADDR_W        (ADDR_W)
	) u_qstate (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (valid_s1),
		.cmd   (cmd_s1),
		.prio  (prio_s1),
		.len   (len_s1),
		.ctl   (ctl),
		.addr  (addr)
	);

	// unused bytes cleared on store
	assign wdata = {len_s1, id_s1, data_s1 & cptq_pkg::byte_mask(len_s1)};

	cptq_ram #(
		.WIDTH (cptq_pkg::SLOT_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_slots (
		.clk  (clk),
		.we   (ctl.wr),
		.waddr(addr),
		.wdata(wdata),
		.re   (ctl.rd),
		.raddr(addr),
		.rdata(rdata)
	);

	assign done          = done_q;
	assign frame_valid   = frame_valid_s3;
	assign frame_id      = frame_id_s3;
	assign frame_length  = frame_length_s3;
	assign frame_data    = frame_data_s3;
	assign length_error  = length_error_s3;
	assign queue_flushed = queue_flushed_s3;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |=> done)
		else $error("word in flight produced no result");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(frame_valid && (length_error || queue_flushed)))
		else $error("send result carries enqueue flags");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && frame_valid) |-> frame_length <= cptq_pkg::LEN_W'(cptq_pkg::MAX_DATA_BYTES))
		else $error("sent frame length above eight");
`endif

endmodule

@@ design/cptq_ram.sv @@
// generic single write port, single read port ram with registered read
module cptq_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/cptq_qstate.sv @@
// per-priority head and count registers, slot address and queue decisions
module cptq_qstate #(
	parameter int NUM_PRIORITIES = cptq_pkg::NUM_PRIORITIES_DEF,
	parameter int QUEUE_LIMIT    = cptq_pkg::QUEUE_LIMIT_DEF,
	parameter int ADDR_W         = $clog2(NUM_PRIORITIES * (QUEUE_LIMIT + 1))
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	input  cptq_pkg::cmd_t              cmd,
	input  logic [cptq_pkg::PRIO_W-1:0] prio,
	input  logic [cptq_pkg::LEN_W-1:0]  len,
	output cptq_pkg::ctl_t              ctl,
	output logic [ADDR_W-1:0]           addr
);

	localparam int SLOTS = QUEUE_LIMIT + 1;
	localparam int HW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int QIW   = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
	localparam logic [4:0] NP5 = 5'(NUM_PRIORITIES);

	logic [HW-1:0]  head_q [NUM_PRIORITIES];
	logic [CW-1:0]  cnt_q  [NUM_PRIORITIES];

	logic [QIW-1:0] pidx;
	logic [QIW-1:0] sel;
	logic           found;
	logic           in_range;
	logic           over;
	logic [CW-1:0]  ccur;
	logic [HW:0]    tail_sum;
	logic [HW-1:0]  tail;

	assign pidx     = QIW'(prio);
	assign in_range = {3'b000, prio} < NP5;
	assign over     = cnt_q[pidx] > CW'(QUEUE_LIMIT);
	assign ccur     = over ? '0 : cnt_q[pidx];
	assign tail_sum = {1'b0, head_q[pidx]} + (HW+1)'(ccur);
	assign tail     = (tail_sum >= (HW+1)'(SLOTS)) ? HW'(tail_sum - (HW+1)'(SLOTS))
		: HW'(tail_sum);

	// lowest index wins
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int q = NUM_PRIORITIES - 1; q >= 0; q--) begin
			if (cnt_q[q] != '0) begin
				found = 1'b1;
				sel   = QIW'(q);
			end
		end
	end

	always_comb begin
		ctl  = '0;
		addr = '0;
		if (valid) begin
			unique case (cmd)
				cptq_pkg::CMD_ENQUEUE: begin
					if (len > cptq_pkg::LEN_W'(cptq_pkg::MAX_DATA_BYTES)) begin
						ctl.len_err = 1'b1;
					end else if (in_range) begin
						ctl.wr      = 1'b1;
						ctl.flushed = over;
						addr        = ADDR_W'(ADDR_W'(pidx) * ADDR_W'(SLOTS)) + ADDR_W'(tail);
					end
				end
				cptq_pkg::CMD_SEND: begin
					if (found) begin
						ctl.rd = 1'b1;
						addr   = ADDR_W'(ADDR_W'(sel) * ADDR_W'(SLOTS)) + ADDR_W'(head_q[sel]);
					end
				end
				default: begin
					ctl = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_PRIORITIES; q++) begin
				head_q[q] <= '0;
				cnt_q[q]  <= '0;
			end
		end else if (ctl.wr) begin
			cnt_q[pidx] <= ccur + CW'(1);
		end else if (ctl.rd) begin
			head_q[sel] <= (head_q[sel] == HW'(SLOTS - 1)) ? '0 : head_q[sel] + HW'(1);
			cnt_q[sel]  <= cnt_q[sel] - CW'(1);
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |-> cnt_q[sel] != '0)
		else $error("pop from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flushed |=> cnt_q[$past(pidx)] == CW'(1))
		else $error("flushed queue does not hold exactly the new word");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr || ctl.rd) |-> int'(addr) < NUM_PRIORITIES * SLOTS)
		else $error("slot address beyond ram depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.len_err |=> cnt_q[$past(pidx)] == $past(cnt_q[pidx]))
		else $error("rejected word changed a queue count");
`endif

endmodule

@@ bench/can_priority_tx_queue_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the strict priority can transmit queue
module can_priority_tx_queue_test;

	localparam int NPRIO        = cptq_pkg::NUM_PRIORITIES_DEF;
	localparam int QLIMIT       = cptq_pkg::QUEUE_LIMIT_DEF;
	localparam int SLOTS        = QLIMIT + 1;
	localparam int CMD_W        = cptq_pkg::CMD_W;
	localparam int PRIO_W       = cptq_pkg::PRIO_W;
	localparam int ID_W         = cptq_pkg::ID_W;
	localparam int LEN_W        = cptq_pkg::LEN_W;
	localparam int DATA_W       = cptq_pkg::DATA_W;
	localparam int MAX_BYTES    = cptq_pkg::MAX_DATA_BYTES;
	localparam int LATENCY      = 3;
	localparam int RANDOM_WORDS = 2000;
	localparam int MAX_REPORTS  = 50;
	localparam int EXP_DEPTH    = 16;

	typedef struct {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
		logic              len_err;
		logic              flushed;
	} tx_word_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CMD_W-1:0]  command;
	logic [PRIO_W-1:0] priority_req;
	logic [ID_W-1:0]   msg_id;
	logic [LEN_W-1:0]  msg_length;
	logic [DATA_W-1:0] msg_data;
	logic              done;
	logic              frame_valid;
	logic [ID_W-1:0]   frame_id;
	logic [LEN_W-1:0]  frame_length;
	logic [DATA_W-1:0] frame_data;
	logic              length_error;
	logic              queue_flushed;

	can_priority_tx_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.priority_req (priority_req),
		.msg_id       (msg_id),
		.msg_length   (msg_length),
		.msg_data     (msg_data),
		.done         (done),
		.frame_valid  (frame_valid),
		.frame_id     (frame_id),
		.frame_length (frame_length),
		.frame_data   (frame_data),
		.length_error (length_error),
		.queue_flushed(queue_flushed)
	);

	// queue state as the bench sees it
	logic [ID_W-1:0]   slot_id    [NPRIO*SLOTS];
	logic [LEN_W-1:0]  slot_len   [NPRIO*SLOTS];
	logic [DATA_W-1:0] slot_bytes [NPRIO*SLOTS];
	int unsigned       fifo_head  [NPRIO];
	int unsigned       fifo_fill  [NPRIO];

	// expected result words in order
	tx_word_t exp_mem [EXP_DEPTH];
	int       exp_wr;
	int       exp_rd;

	int n_errors;
	int n_words;
	int n_checked;
	int n_stored;
	int n_sent;
	int n_empty_sends;
	int n_len_errors;
	int n_flushes;
	int burst_left;
	bit pacing_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int n_pending();
		return exp_wr - exp_rd;
	endfunction

	initial begin
		#5ms;
		$display("timeout with %0d result words outstanding", n_pending());
		$display("can_priority_tx_queue_test failed");
		$finish;
	end

	task automatic report_mismatch(string msg);
		if (n_errors < MAX_REPORTS)
			$display("ERROR at %0t: %s", $time, msg);
		n_errors++;
	endtask

	function automatic logic [DATA_W-1:0] keep_bytes(logic [LEN_W-1:0] len);
		if (len >= MAX_BYTES)
			return '1;
		return (64'd1 << (len * 8)) - 64'd1;
	endfunction

	function automatic tx_word_t predict_tx_queue(cptq_pkg::cmd_t cmd, logic [PRIO_W-1:0] prio,
			logic [ID_W-1:0] id, logic [LEN_W-1:0] len, logic [DATA_W-1:0] data);
		tx_word_t    w;
		int unsigned slot;
		bit          found;
		w = '{default: '0};
		found = 1'b0;
		if (cmd == cptq_pkg::CMD_ENQUEUE) begin
			if (len > MAX_BYTES) begin
				w.len_err = 1'b1;
				n_len_errors++;
			end else if (prio < NPRIO) begin
				if (fifo_fill[prio] > QLIMIT) begin
					fifo_fill[prio] = 0;
					w.flushed = 1'b1;
					n_flushes++;
				end
				slot = prio * SLOTS + (fifo_head[prio] + fifo_fill[prio]) % SLOTS;
				slot_id[slot] = id;
				slot_len[slot] = len;
				slot_bytes[slot] = data & keep_bytes(len);
				fifo_fill[prio]++;
				n_stored++;
			end
		end else begin
			for (int q = 0; q < NPRIO; q++) begin
				if (!found && fifo_fill[q] != 0) begin
					slot = q * SLOTS + fifo_head[q];
					w.valid = 1'b1;
					w.id = slot_id[slot];
					w.len = slot_len[slot];
					w.data = slot_bytes[slot] & keep_bytes(slot_len[slot]);
					fifo_head[q] = (fifo_head[q] + 1) % SLOTS;
					fifo_fill[q]--;
					found = 1'b1;
				end
			end
			if (found)
				n_sent++;
			else
				n_empty_sends++;
		end
		return w;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(cptq_pkg::cmd_t cmd, logic [PRIO_W-1:0] prio, logic [ID_W-1:0] id,
			logic [LEN_W-1:0] len, logic [DATA_W-1:0] data);
		command <= cmd;
		priority_req <= prio;
		msg_id <= id;
		msg_length <= len;
		msg_data <= data;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (n_pending() >= EXP_DEPTH)
			report_mismatch("too many result words outstanding");
		exp_mem[exp_wr % EXP_DEPTH] = predict_tx_queue(cmd, prio, id, len, data);
		exp_wr++;
		n_words++;
		@(negedge clk);
	endtask

	task automatic pause_cycles(int n);
		start <= 1'b0;
		command <= CMD_W'($urandom);
		priority_req <= PRIO_W'($urandom);
		msg_id <= ID_W'($urandom);
		msg_length <= LEN_W'($urandom);
		msg_data <= {$urandom, $urandom};
		repeat (n)
			@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (n_pending() != 0);
	endtask

	task automatic pace();
		if (!pacing_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(24, 1);
		pause_cycles($urandom_range(7, 1));
	endtask

	task automatic send_random_word(int enq_pct, int hot_pct, logic [PRIO_W-1:0] hot_prio);
		cptq_pkg::cmd_t    cmd;
		logic [PRIO_W-1:0] prio;
		logic [LEN_W-1:0]  len;
		cmd = ($urandom_range(99) < enq_pct) ? cptq_pkg::CMD_ENQUEUE : cptq_pkg::CMD_SEND;
		prio = ($urandom_range(99) < hot_pct) ? hot_prio : PRIO_W'($urandom);
		len = ($urandom_range(99) < 8) ? LEN_W'($urandom_range(15, 9))
			: LEN_W'($urandom_range(8, 0));
		send_word(cmd, prio, ID_W'($urandom), len, {$urandom, $urandom});
		pace();
	endtask

	task automatic test_frame_fields();
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd0, 11'h7FF, 4'd8, '1);
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd0, 11'h000, 4'd0, '1);
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd0, 11'h2AA, 4'd1, '1);
		send_word(cptq_pkg::CMD_SEND, 2'd0, 11'h000, 4'd0, '0);
		send_word(cptq_pkg::CMD_SEND, 2'd3, 11'h7FF, 4'd15, '1);
		send_word(cptq_pkg::CMD_SEND, 2'd0, 11'h000, 4'd0, '0);
		// nothing waiting
		send_word(cptq_pkg::CMD_SEND, 2'd0, 11'h000, 4'd0, '0);
	endtask

	task automatic test_length_errors();
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd0, 11'h123, 4'd9, 64'h0123_4567_89AB_CDEF);
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd3, 11'h7FF, 4'd15, '1);
		send_word(cptq_pkg::CMD_SEND, 2'd0, 11'h000, 4'd0, '0);
	endtask

	task automatic test_priority_order();
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd3, 11'h300, 4'd2, {$urandom, $urandom});
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd2, 11'h200, 4'd3, {$urandom, $urandom});
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd1, 11'h100, 4'd4, {$urandom, $urandom});
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd0, 11'h000, 4'd5, {$urandom, $urandom});
		send_word(cptq_pkg::CMD_ENQUEUE, 2'd1, 11'h101, 4'd7, {$urandom, $urandom});
		repeat (6)
			send_word(cptq_pkg::CMD_SEND, 2'd0, 11'h000, 4'd0, '0);
	endtask

	task automatic test_queue_flush();
		logic [PRIO_W-1:0] prio;
		prio = PRIO_W'($urandom);
		// one past full empties the fifo before storing
		repeat (QLIMIT + 2)
			send_word(cptq_pkg::CMD_ENQUEUE, prio, ID_W'($urandom),
				LEN_W'($urandom_range(8, 0)), {$urandom, $urandom});
		repeat (2)
			send_word(cptq_pkg::CMD_SEND, 2'd0, 11'h000, 4'd0, '0);
	endtask

	task automatic test_random_traffic();
		int                stop_at;
		int                phase_len;
		int                kind;
		logic [PRIO_W-1:0] hot_prio;
		stop_at = n_words + RANDOM_WORDS;
		while (n_words < stop_at) begin
			kind = $urandom_range(9);
			phase_len = $urandom_range(80, 20);
			hot_prio = PRIO_W'($urandom);
			pacing_on = ($urandom_range(3) != 0);
			burst_left = 0;
			repeat (phase_len) begin
				if (kind < 5)
					send_random_word(55, 0, hot_prio);
				else if (kind < 8)
					send_random_word(92, 85, hot_prio);
				else
					send_random_word(15, 0, hot_prio);
			end
			if ($urandom_range(4) == 0)
				wait_idle();
		end
		pacing_on = 1'b0;
	endtask

	always @(posedge clk) begin
		tx_word_t want;
		if (arst_n && done) begin
			if (n_pending() == 0) begin
				report_mismatch("result word with none expected");
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				n_checked++;
				if (frame_valid !== want.valid)
					report_mismatch($sformatf("frame_valid: got %0h, expected %0h",
						frame_valid, want.valid));
				if (frame_id !== want.id)
					report_mismatch($sformatf("frame_id: got %0h, expected %0h",
						frame_id, want.id));
				if (frame_length !== want.len)
					report_mismatch($sformatf("frame_length: got %0h, expected %0h",
						frame_length, want.len));
				if (frame_data !== want.data)
					report_mismatch($sformatf("frame_data: got %0h, expected %0h",
						frame_data, want.data));
				if (length_error !== want.len_err)
					report_mismatch($sformatf("length_error: got %0h, expected %0h",
						length_error, want.len_err));
				if (queue_flushed !== want.flushed)
					report_mismatch($sformatf("queue_flushed: got %0h, expected %0h",
						queue_flushed, want.flushed));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= cptq_pkg::CMD_ENQUEUE;
		priority_req <= '0;
		msg_id <= '0;
		msg_length <= '0;
		msg_data <= '0;
		exp_wr = 0;
		exp_rd = 0;
		for (int q = 0; q < NPRIO; q++) begin
			fifo_head[q] = 0;
			fifo_fill[q] = 0;
		end
		pacing_on = 1'b0;
		burst_left = 0;
		repeat (7)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_frame_fields();
		test_length_errors();
		test_priority_order();
		wait_idle();
		test_queue_flush();
		wait_idle();
		test_random_traffic();

		start <= 1'b0;
		for (int i = 0; i < 100 && n_pending() != 0; i++)
			@(posedge clk);
		if (n_pending() != 0) begin
			report_mismatch($sformatf("%0d result words never arrived", n_pending()));
			exp_rd = exp_wr;
		end
		repeat (LATENCY + 4)
			@(posedge clk);

		$display("sent %0d command words and checked %0d results", n_words, n_checked);
		$display("%0d frames queued, %0d popped, %0d sends on empty queues,",
			n_stored, n_sent, n_empty_sends);
		$display("%0d length errors, %0d flushes", n_len_errors, n_flushes);
		if (n_errors == 0)
			$display("can_priority_tx_queue_test passed");
		else
			$display("can_priority_tx_queue_test failed");
		$finish;
	end

endmodule
